// ===== rtl/delta_varint_postings_decoder_assert.svh =====
// Assertion macros used by the decoder top level.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is high.
`ifndef DELTA_VARINT_POSTINGS_DECODER_ASSERT_SVH
`define DELTA_VARINT_POSTINGS_DECODER_ASSERT_SVH

// Same-cycle implication.
`define DVPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DVPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dvpd_pkg.sv =====
`timescale 1ns / 1ps

package dvpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int DIGIT_W  = 7;
  localparam int LEN_W    = 32;
  localparam int MORE_BIT = 7;

  typedef enum logic {
    STATUS_OK           = 1'b0,
    STATUS_FORMAT_ERROR = 1'b1
  } status_t;

  // Side flags that travel with every result.
  typedef struct packed {
    logic    last_of_list;
    status_t status;
  } res_flags_t;

endpackage

// ===== rtl/dvpd_in_reg.sv =====
`timescale 1ns / 1ps

// Input register: captures one request and holds it until the decode
// stage consumes it.
module dvpd_in_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dvpd_pkg::BYTE_W-1:0]      data_byte,
  input  logic                             list_start,
  input  logic [dvpd_pkg::LEN_W-1:0]       list_length,
  input  logic                             advance,
  output logic                             s1_valid,
  output logic [dvpd_pkg::BYTE_W-1:0]      s1_byte,
  output logic                             s1_start,
  output logic [dvpd_pkg::LEN_W-1:0]       s1_length
);

  logic load;

  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_byte   <= data_byte;
      s1_start  <= list_start;
      s1_length <= list_length;
    end
  end

endmodule

// ===== rtl/dvpd_decode.sv =====
`timescale 1ns / 1ps

// Varint gathering, delta accumulation and list bookkeeping for one byte.
module dvpd_decode #(
  parameter int ID_WIDTH         = 32,
  parameter int MAX_VARINT_BYTES = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [dvpd_pkg::BYTE_W-1:0]  s1_byte,
  input  logic                         s1_start,
  input  logic [dvpd_pkg::LEN_W-1:0]   s1_length,
  output logic                         res_valid,
  output logic [ID_WIDTH-1:0]          res_id,
  output dvpd_pkg::res_flags_t         res_flags
);

  localparam int ACC_W = dvpd_pkg::DIGIT_W * MAX_VARINT_BYTES;
  localparam int SH_W  = (ACC_W > ID_WIDTH) ? ACC_W : ID_WIDTH;
  localparam int SA_W  = $clog2(SH_W);
  localparam int POS_W = $clog2(MAX_VARINT_BYTES);

  logic [ID_WIDTH-1:0]            partial_value, partial_value_next;
  logic [POS_W-1:0]               byte_position, byte_position_next;
  logic [ID_WIDTH-1:0]            running_id, running_id_next;
  logic [dvpd_pkg::LEN_W-1:0]     ids_remaining, ids_remaining_next;
  logic                           first_pending, first_pending_next;
  logic                           error_hold, error_hold_next;

  logic [ID_WIDTH-1:0]            pv_eff, run_eff, pv_or, id_sum;
  logic [POS_W-1:0]               pos_eff;
  logic [dvpd_pkg::LEN_W-1:0]     ids_eff;
  logic                           first_eff, err_eff, drop, more, too_long;
  logic [SA_W-1:0]                shamt;
  logic [SH_W-1:0]                shifted;

  // A list start wipes the per-list state before this same byte is used.
  always_comb begin
    pv_eff    = s1_start ? '0 : partial_value;
    pos_eff   = s1_start ? '0 : byte_position;
    run_eff   = s1_start ? '0 : running_id;
    ids_eff   = s1_start ? s1_length : ids_remaining;
    first_eff = s1_start ? 1'b1 : first_pending;
    err_eff   = s1_start ? 1'b0 : error_hold;
  end

  assign drop     = err_eff || (ids_eff == '0);
  assign more     = s1_byte[dvpd_pkg::MORE_BIT];
  assign too_long = (pos_eff == POS_W'(MAX_VARINT_BYTES - 1));

  // Place the seven payload bits; bits above the id width fall away.
  assign shamt   = SA_W'(pos_eff) * SA_W'(dvpd_pkg::DIGIT_W);
  assign shifted = SH_W'(s1_byte[dvpd_pkg::DIGIT_W-1:0]) << shamt;
  assign pv_or   = pv_eff | shifted[ID_WIDTH-1:0];
  assign id_sum  = first_eff ? pv_or : (run_eff + pv_or);

  always_comb begin
    partial_value_next = pv_eff;
    byte_position_next = pos_eff;
    running_id_next    = run_eff;
    ids_remaining_next = ids_eff;
    first_pending_next = first_eff;
    error_hold_next    = err_eff;
    res_valid          = 1'b0;
    res_id             = '0;
    res_flags          = '{last_of_list: 1'b0, status: dvpd_pkg::STATUS_OK};
    if (!drop) begin
      if (more) begin
        if (too_long) begin
          partial_value_next = '0;
          byte_position_next = '0;
          error_hold_next    = 1'b1;
          res_valid          = 1'b1;
          res_flags.status   = dvpd_pkg::STATUS_FORMAT_ERROR;
        end else begin
          partial_value_next = pv_or;
          byte_position_next = pos_eff + POS_W'(1);
        end
      end else begin
        partial_value_next     = '0;
        byte_position_next     = '0;
        running_id_next        = id_sum;
        first_pending_next     = 1'b0;
        ids_remaining_next     = ids_eff - dvpd_pkg::LEN_W'(1);
        res_valid              = 1'b1;
        res_id                 = id_sum;
        res_flags.last_of_list = (ids_eff == dvpd_pkg::LEN_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      byte_position <= '0;
      running_id    <= '0;
      ids_remaining <= '0;
      first_pending <= 1'b1;
      error_hold    <= 1'b0;
    end else if (fire) begin
      partial_value <= partial_value_next;
      byte_position <= byte_position_next;
      running_id    <= running_id_next;
      ids_remaining <= ids_remaining_next;
      first_pending <= first_pending_next;
      error_hold    <= error_hold_next;
    end
  end

endmodule

// ===== rtl/dvpd_out_reg.sv =====
`timescale 1ns / 1ps

// Result register: holds one result until the receiver takes it.
module dvpd_out_reg #(
  parameter int ID_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic                  res_valid,
  input  logic [ID_WIDTH-1:0]   res_id,
  input  dvpd_pkg::res_flags_t  res_flags,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ID_WIDTH-1:0]   record_id,
  output logic                  last_of_list,
  output logic                  status
);

  logic load;

  assign out_free = !out_valid || !out_stall;
  assign load     = fire && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      record_id    <= res_id;
      last_of_list <= res_flags.last_of_list;
      status       <= res_flags.status;
    end
  end

endmodule

// ===== rtl/delta_varint_postings_decoder.sv =====
`timescale 1ns / 1ps

// Posting-list decoder for delta-coded base-128 varints.
// Input channel (in_valid / in_stall) carries one encoded byte per request.
// list_start marks the first byte of a list; list_length, sampled only with
// it, gives the number of ids in that list. Each varint is little-endian,
// seven payload bits per byte, bit 7 set meaning another byte follows.
// The first value of a list is an absolute id, later values are deltas added
// with wrap at ID_WIDTH bits. Output channel (out_valid / out_stall) carries
// one request per finished id, with last_of_list on the final id, or one
// format-error request (status set, id zero) when a varint reaches
// MAX_VARINT_BYTES bytes and still asks for more; the rest of that list is
// then dropped. Bytes beyond the id count, or before any list start, are
// dropped without a result.
// A byte held in the input register is decoded combinationally, and its result
// is loaded into the result register once that register is free.
// Throughput: one byte per cycle unless the output stalls; the input register
// feeds the decode logic and the result register directly, with no iteration.
// Reset clears both registers and the list state; no list is open after it.
// A stalled result holds in the result register; one more byte waits in the
// input register, and only then does in_stall rise.
module delta_varint_postings_decoder #(
  parameter int ID_WIDTH         = 32,
  parameter int MAX_VARINT_BYTES = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dvpd_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         list_start,
  input  logic [dvpd_pkg::LEN_W-1:0]   list_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ID_WIDTH-1:0]          record_id,
  output logic                         last_of_list,
  output logic                         status
);

`include "delta_varint_postings_decoder_assert.svh"

  logic                          s1_valid;
  logic [dvpd_pkg::BYTE_W-1:0]   s1_byte;
  logic                          s1_start;
  logic [dvpd_pkg::LEN_W-1:0]    s1_length;
  logic                          out_free;
  logic                          fire;
  logic                          res_valid;
  logic [ID_WIDTH-1:0]           res_id;
  dvpd_pkg::res_flags_t          res_flags;

  // The held byte is decoded whenever the result register can take a result.
  assign fire = s1_valid && out_free;

  dvpd_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .list_start  (list_start),
    .list_length (list_length),
    .advance     (out_free),
    .s1_valid    (s1_valid),
    .s1_byte     (s1_byte),
    .s1_start    (s1_start),
    .s1_length   (s1_length)
  );

  dvpd_decode #(
    .ID_WIDTH         (ID_WIDTH),
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .s1_byte   (s1_byte),
    .s1_start  (s1_start),
    .s1_length (s1_length),
    .res_valid (res_valid),
    .res_id    (res_id),
    .res_flags (res_flags)
  );

  dvpd_out_reg #(
    .ID_WIDTH (ID_WIDTH)
  ) u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .res_valid    (res_valid),
    .res_id       (res_id),
    .res_flags    (res_flags),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .record_id    (record_id),
    .last_of_list (last_of_list),
    .status       (status)
  );

  // A format-error result never carries an id or an end-of-list mark.
  `DVPD_ASSERT_IMPLY(a_err_clean, clk, rst,
    out_valid && (status == dvpd_pkg::STATUS_FORMAT_ERROR),
    (record_id == '0) && !last_of_list, "error result carries id or last mark")

  // The input side only stalls while a byte is actually held.
  `DVPD_ASSERT_IMPLY(a_stall_held, clk, rst, in_stall, s1_valid,
    "input stalled with empty input register")

  // With no byte held and no stalled result, no result can appear next cycle.
  `DVPD_ASSERT_NEXT(a_no_phantom, clk, rst,
    !s1_valid && !(out_valid && out_stall), !out_valid,
    "result appeared without a decoded byte")

endmodule
